>>> hw/rtl/lrufr_pkg.sv
// Shared types and constants for the LRU frame replacer.
// Used by lrufr_list and lru_frame_replacer; depends on nothing.
package lrufr_pkg;

   // Number of buffer frames tracked by the list.
   localparam int FRAMES  = 64;
   // Field widths fixed by the event and result formats.
   localparam int MODE_W  = 2;
   localparam int FRAME_W = 6;
   localparam int COUNT_W = 7;

   // Event kinds; the code left over is treated as a no-op.
   typedef enum logic [MODE_W-1:0] {
      MODE_VICTIM = 2'd0,
      MODE_PIN    = 2'd1,
      MODE_UNPIN  = 2'd2
   } mode_type;

   // One event as held in the input register.
   typedef struct packed {
      logic [MODE_W-1:0]  mode;
      logic [FRAME_W-1:0] frame;
   } cmd_type;

   // One result as held in the output register.
   typedef struct packed {
      logic               victim_valid;
      logic [FRAME_W-1:0] victim_frame;
      logic [COUNT_W-1:0] count;
   } result_type;

endpackage

>>> hw/rtl/lrufr_list.sv
// Ordered frame list with presence flags, updated in a single pass per event.
// Depends on lrufr_pkg.
module lrufr_list (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  lrufr_pkg::cmd_type    cmd,
   output lrufr_pkg::result_type result
);

   localparam logic [lrufr_pkg::COUNT_W-1:0] FRAMES_C = lrufr_pkg::COUNT_W'(lrufr_pkg::FRAMES);

   // List entries, oldest at index 0; only entries below the count are meaningful.
   logic [lrufr_pkg::FRAME_W-1:0] order_ff [lrufr_pkg::FRAMES];
   logic [lrufr_pkg::FRAMES-1:0]  present_ff, present_in;
   logic [lrufr_pkg::COUNT_W-1:0] count_ff, count_in;

   logic [lrufr_pkg::FRAMES-1:0]  live, match, below, shift, wr;
   logic nonempty, full, frame_ok, hit;
   logic is_victim, is_pin, is_unpin;
   logic do_victim, do_pin, do_unpin;

   // Event decode
   always_comb begin
      is_victim = 1'b0;
      is_pin    = 1'b0;
      is_unpin  = 1'b0;
      unique case (lrufr_pkg::mode_type'(cmd.mode))
         lrufr_pkg::MODE_VICTIM: is_victim = 1'b1;
         lrufr_pkg::MODE_PIN:    is_pin    = 1'b1;
         lrufr_pkg::MODE_UNPIN:  is_unpin  = 1'b1;
         default: ;
      endcase
   end

   assign nonempty  = (count_ff != '0);
   assign full      = (count_ff == FRAMES_C);
   assign frame_ok  = (lrufr_pkg::COUNT_W'(cmd.frame) < FRAMES_C);
   assign hit       = present_ff[cmd.frame];

   assign do_victim = step && is_victim && nonempty;
   assign do_pin    = step && is_pin && frame_ok && hit;
   assign do_unpin  = step && is_unpin && frame_ok && !hit && !full;

   // Per-entry match, shift and write enables
   for (genvar i = 0; i < lrufr_pkg::FRAMES; i++) begin : g_entry
      assign live[i]  = (lrufr_pkg::COUNT_W'(i) < count_ff);
      assign match[i] = live[i] && (order_ff[i] == cmd.frame);
      // entry at or above the removed one moves down by one place
      assign below[i] = |match[i:0];
      assign shift[i] = do_victim || (do_pin && below[i]);
      assign wr[i]    = do_unpin && (lrufr_pkg::COUNT_W'(i) == count_ff);

      if (i < lrufr_pkg::FRAMES - 1) begin : g_mid
         always_ff @(posedge clock) begin
            if (shift[i]) begin
               order_ff[i] <= order_ff[i+1];
            end else if (wr[i]) begin
               order_ff[i] <= cmd.frame;
            end
         end
      end else begin : g_last
         always_ff @(posedge clock) begin
            if (wr[i]) begin
               order_ff[i] <= cmd.frame;
            end
         end
      end
   end

   // Presence flags and count
   always_comb begin
      present_in = present_ff;
      count_in   = count_ff;
      if (do_victim) begin
         present_in[order_ff[0]] = 1'b0;
         count_in = count_ff - 1'b1;
      end
      if (do_pin) begin
         present_in[cmd.frame] = 1'b0;
         count_in = count_ff - 1'b1;
      end
      if (do_unpin) begin
         present_in[cmd.frame] = 1'b1;
         count_in = count_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         present_ff <= '0;
         count_ff   <= '0;
      end else begin
         present_ff <= present_in;
         count_ff   <= count_in;
      end
   end

   // Result of this event
   assign result.victim_valid = do_victim;
   assign result.victim_frame = do_victim ? order_ff[0] : '0;
   assign result.count        = count_in;

`ifndef NO_ASSERTIONS
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FRAMES_C)
      else $error("list count above frame total");

   a_flags_match_count: assert property (@(posedge clock) disable iff (reset)
      lrufr_pkg::COUNT_W'($countones(present_ff)) == count_ff)
      else $error("presence flags disagree with list count");

   a_victim_was_present: assert property (@(posedge clock) disable iff (reset)
      do_victim |-> present_ff[order_ff[0]])
      else $error("evicted frame not flagged present");

   a_victim_shrinks: assert property (@(posedge clock) disable iff (reset)
      do_victim |=> count_ff == $past(count_ff) - 1'b1)
      else $error("eviction did not shrink the list");

   a_unpin_appends: assert property (@(posedge clock) disable iff (reset)
      do_unpin |=> present_ff[$past(cmd.frame)]
                   && order_ff[$past(count_ff[lrufr_pkg::COUNT_W-2:0])] == $past(cmd.frame))
      else $error("unpinned frame not appended");
`endif

endmodule

>>> hw/rtl/lru_frame_replacer.sv
// Top level of the LRU frame replacer: input register, list update, result register.
// Depends on lrufr_pkg and lrufr_list.

// Accepts one event per cycle while req_stall is low and returns one result per
// event. The input register takes the event when it is accepted and the result
// register loads when the event advances, so rsp_valid rises once the result
// register holds it. The update of the 64-entry shift-register list and its
// presence flags completes combinationally between those registers, so
// back-to-back events see each other's effects with no bubbles. Reset clears
// the flags and count; the list entries need no clearing. A stalled result holds
// the pipeline and raises req_stall only once the input register is also occupied.
module lru_frame_replacer (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [lrufr_pkg::MODE_W-1:0]        req_mode,
   input  logic [lrufr_pkg::FRAME_W-1:0]       req_frame,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_victim_valid,
   output logic [lrufr_pkg::FRAME_W-1:0]       rsp_victim_frame,
   output logic [lrufr_pkg::COUNT_W-1:0]       rsp_evictable_count
);

   logic                  stage_valid_ff, stage_valid_in;
   lrufr_pkg::cmd_type    stage_cmd_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   lrufr_pkg::result_type rsp_result_ff;
   lrufr_pkg::result_type list_result;
   logic                  advance;

   // Pipeline control
   assign advance   = stage_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = stage_valid_ff && !advance;

   always_comb begin
      stage_valid_in = stage_valid_ff;
      if (!req_stall) begin
         stage_valid_in = req_valid;
      end
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // Input register
   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         stage_cmd_ff.mode  <= req_mode;
         stage_cmd_ff.frame <= req_frame;
      end
   end

   lrufr_list u_list (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .cmd    (stage_cmd_ff),
      .result (list_result)
   );

   // Result register
   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_result_ff <= list_result;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_victim_valid    = rsp_result_ff.victim_valid;
   assign rsp_victim_frame    = rsp_result_ff.victim_frame;
   assign rsp_evictable_count = rsp_result_ff.count;

endmodule
